// ===== rtl/dpod_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpod_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MON_W    = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned DATE_W   = YEAR_W + MON_W + DAY_W;
  localparam int unsigned N_DATES  = 4;
  localparam int unsigned IN_W     = 96;  // 4 dates of 23 bits, padded to bytes
  localparam int unsigned SER_W    = 22;  // day serial and day count
  localparam int unsigned OUT_W    = 24;  // count padded to bytes

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W  = YEAR_W + 1;
  localparam int unsigned MUL_B_W  = 13;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  localparam logic [YEAR_W-1:0]  MAX_YEAR      = YEAR_W'(9999);
  localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = MUL_B_W'(365);
  // x / 100 = (x * 5243) >> 19 and x / 400 = (x * 5243) >> 21, exact for x < 43690
  localparam logic [MUL_B_W-1:0] RECIP_100     = MUL_B_W'(5243);
  localparam int unsigned        SHIFT_100     = 19;
  localparam int unsigned        SHIFT_400     = 21;
  localparam logic [MUL_B_W-1:0] CENTURY       = MUL_B_W'(100);
  localparam logic [MUL_B_W-1:0] QUAD_CENTURY  = MUL_B_W'(400);
  localparam logic [MON_W-1:0]   MONTH_FEB     = MON_W'(2);
  localparam logic [MON_W-1:0]   MONTHS        = MON_W'(12);

  localparam int unsigned Q100_W = PROD_W - SHIFT_100;
  localparam int unsigned Q400_W = PROD_W - SHIFT_400;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR,     // y * 365
    ST_BASE,     // add y*365, ceil(y/4), month offset, day
    ST_CENT,     // subtract ceil(y/100)
    ST_QUAD,     // add ceil(y/400)
    ST_FLOOR,    // floor(y/100), floor(y/400)
    ST_BACK100,  // floor(y/100) * 100 == y ?
    ST_LEAP,     // floor(y/400) * 400 == y ? ; finish date
    ST_LEN1,
    ST_LEN2,
    ST_LO,
    ST_HI,
    ST_DONE
  } state_e;

  // days before month m in a common year; invalid months give 0
  function automatic logic [8:0] month_offset(input logic [MON_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/date_period_overlap_days.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Day-overlap counter for two Gregorian date periods. One input transaction
// carries both periods (start and end date each); one output transaction gives
// the number of shared days in tdata and a bad-date flag in tuser. The shorter
// period (period two on a tie, length counting start but not end) is walked
// from start up to but not including its end, and days inside the other period,
// both bounds counted, are tallied; periods that do not touch give 0. Any
// invalid date (month out of 1..12, day out of range, year above 9999) sets
// the flag and forces the count to 0. Each date is turned into a day serial by
// one shared 15x13 multiplier and one accumulator in the steps ST_YEAR to
// ST_LEAP, then ST_LEN1, ST_LEN2, ST_LO and ST_HI compare and subtract to
// finish the count. The input is not ready while a transaction is worked on,
// only in the idle state; a finished result waits in the output register and
// the next transaction may be accepted while it waits.

module date_period_overlap_days (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // low to high: first_start_year, first_start_month, first_start_day,
  // first_end_year, first_end_month, first_end_day, second_start_year,
  // second_start_month, second_start_day, second_end_year, second_end_month,
  // second_end_day, 4 zero bits
  input  wire  [dpod_pkg::IN_W-1:0]      s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // low to high: overlap_days, 2 zero bits
  output logic [dpod_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // bad_date
  output logic [0:0]                     m_axis_tuser_o
);
  import dpod_pkg::*;

  state_e state_q, state_d;

  // captured dates: first start, first end, second start, second end
  date_t            dates_q [N_DATES];
  date_t            dates_in [N_DATES];
  logic [1:0]       di_q, di_d;        // date being converted
  logic [SER_W-1:0] ser_q [N_DATES];
  logic [SER_W-1:0] ser_d;
  logic             ser_we;

  logic [SER_W-1:0] acc_q, acc_d;      // serial accumulator
  logic [PROD_W-1:0] prod_q;           // registered multiplier output
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [Q400_W-1:0] q400_q, q400_d;
  logic             z100_q, z100_d;    // year is a multiple of 100
  logic             bad_q, bad_d;
  logic             sep_q, sep_d;      // periods do not touch
  logic [SER_W-1:0] len1_q, len1_d, len2_q, len2_d;
  logic [SER_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic             walk1_q, walk1_d;  // period one is the walking period

  logic             out_valid_q;
  logic [SER_W-1:0] out_cnt_q;
  logic             out_bad_q;
  logic             out_load;
  logic [SER_W-1:0] cnt;

  date_t            cur;
  logic [MUL_A_W-1:0] y15;
  logic             leap;
  logic             date_ok;
  logic [SER_W-1:0] we, oe1;

  // unpack the four dates
  always_comb begin
    for (int k = 0; k < N_DATES; k++) begin
      dates_in[k].year  = s_axis_tdata_i[DATE_W*k +: YEAR_W];
      dates_in[k].month = s_axis_tdata_i[DATE_W*k + YEAR_W +: MON_W];
      dates_in[k].day   = s_axis_tdata_i[DATE_W*k + YEAR_W + MON_W +: DAY_W];
    end
  end

  assign cur = dates_q[di_q];
  assign y15 = {1'b0, cur.year};
  assign prod = mul_a * mul_b;

  // leap check from back-multiplied quotients
  assign leap = (prod_q == PROD_W'(cur.year)) ||
                ((cur.year[1:0] == 2'b00) && !z100_q);
  assign date_ok = (cur.year <= MAX_YEAR) && (cur.day != '0) &&
                   (cur.day <= month_days(cur.month, leap));

  assign we  = walk1_q ? ser_q[1] : ser_q[3];
  assign oe1 = (walk1_q ? ser_q[3] : ser_q[1]) + SER_W'(1);
  assign cnt = (bad_q || sep_q || (hi_q <= lo_q)) ? '0 : hi_q - lo_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_axis_tvalid_i) state_d = ST_YEAR;
      ST_YEAR:    state_d = ST_BASE;
      ST_BASE:    state_d = ST_CENT;
      ST_CENT:    state_d = ST_QUAD;
      ST_QUAD:    state_d = ST_FLOOR;
      ST_FLOOR:   state_d = ST_BACK100;
      ST_BACK100: state_d = ST_LEAP;
      ST_LEAP:    state_d = (di_q == 2'd3) ? ST_LEN1 : ST_YEAR;
      ST_LEN1:    state_d = ST_LEN2;
      ST_LEN2:    state_d = ST_LO;
      ST_LO:      state_d = ST_HI;
      ST_HI:      state_d = ST_DONE;
      ST_DONE:    if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath controls and next values
  always_comb begin
    mul_a    = y15;
    mul_b    = RECIP_100;
    acc_d    = acc_q;
    q400_d   = q400_q;
    z100_d   = z100_q;
    bad_d    = bad_q;
    sep_d    = sep_q;
    di_d     = di_q;
    ser_d    = acc_q;
    ser_we   = 1'b0;
    len1_d   = len1_q;
    len2_d   = len2_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    walk1_d  = walk1_q;
    out_load = 1'b0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        di_d  = '0;
        bad_d = 1'b0;
      end
      ST_YEAR: begin
        mul_b = DAYS_PER_YEAR;
      end
      ST_BASE: begin
        acc_d = prod_q[SER_W-1:0]
              + SER_W'((y15 + MUL_A_W'(3)) >> 2)
              + SER_W'(month_offset(cur.month))
              + SER_W'(cur.day) - SER_W'(1);
        mul_a = y15 + MUL_A_W'(99);
      end
      ST_CENT: begin
        acc_d = acc_q - SER_W'(prod_q[PROD_W-1:SHIFT_100]);
        mul_a = y15 + MUL_A_W'(399);
      end
      ST_QUAD: begin
        acc_d = acc_q + SER_W'(prod_q[PROD_W-1:SHIFT_400]);
      end
      ST_FLOOR: begin
        q400_d = prod_q[PROD_W-1:SHIFT_400];
        mul_a  = MUL_A_W'(prod_q[PROD_W-1:SHIFT_100]);
        mul_b  = CENTURY;
      end
      ST_BACK100: begin
        z100_d = (prod_q == PROD_W'(cur.year));
        mul_a  = MUL_A_W'(q400_q);
        mul_b  = QUAD_CENTURY;
      end
      ST_LEAP: begin
        ser_d  = acc_q + SER_W'(leap && (cur.month > MONTH_FEB));
        ser_we = 1'b1;
        bad_d  = bad_q | !date_ok;
        di_d   = di_q + 2'd1;
      end
      ST_LEN1: begin
        len1_d = (ser_q[1] > ser_q[0]) ? ser_q[1] - ser_q[0] : '0;
        sep_d  = (ser_q[3] < ser_q[0]);
      end
      ST_LEN2: begin
        len2_d = (ser_q[3] > ser_q[2]) ? ser_q[3] - ser_q[2] : '0;
        sep_d  = sep_q | (ser_q[2] > ser_q[1]);
      end
      ST_LO: begin
        walk1_d = (len1_q < len2_q);
        // lo is the later of the two starts either way
        lo_d    = (ser_q[0] > ser_q[2]) ? ser_q[0] : ser_q[2];
      end
      ST_HI: begin
        hi_d = (we < oe1) ? we : oe1;
      end
      ST_DONE: begin
        out_load = !out_valid_q || m_axis_tready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      di_q        <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      di_q    <= di_d;
      bad_q   <= bad_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      for (int k = 0; k < N_DATES; k++) begin
        dates_q[k] <= dates_in[k];
      end
    end
    if (ser_we) begin
      ser_q[di_q] <= ser_d;
    end
    prod_q  <= prod;
    acc_q   <= acc_d;
    q400_q  <= q400_d;
    z100_q  <= z100_d;
    sep_q   <= sep_d;
    len1_q  <= len1_d;
    len2_q  <= len2_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    walk1_q <= walk1_d;
    if (out_load) begin
      out_cnt_q <= cnt;
      out_bad_q <= bad_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W-SER_W){1'b0}}, out_cnt_q};
  assign m_axis_tuser_o  = out_bad_q;

endmodule

`default_nettype wire

// ===== verif/overlap_days_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels, predicts the shared-day count for every accepted
// transaction and compares each result, in order, with the oldest prediction.
module overlap_days_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [dpod_pkg::IN_W-1:0]  s_tdata_i,
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic [dpod_pkg::OUT_W-1:0] m_tdata_i,
  input  logic [0:0]                 m_tuser_i,
  output int                         errors_o,
  output int                         pending_o
);
  import dpod_pkg::*;

  localparam int unsigned LAST_YEAR = 9999;
  localparam int unsigned COUNT_W   = 22;
  localparam longint      COUNT_TOP = 64'h3F_FFFF;

  typedef struct packed {
    logic [COUNT_W-1:0] days;
    logic               bad;
  } overlap_t;

  overlap_t due_overlaps[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report(input string what);
    if (errors_o < 100) begin
      $display("%0t overlap check: %s", $time, what);
    end
    errors_o++;
  endtask

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = leap_year(y) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic bit date_good(input date_t d);
    return (d.year <= LAST_YEAR) && (d.day >= 1) && (d.day <= days_in(d.month, d.year));
  endfunction

  // days since 0000-01-01; only called for valid dates
  function automatic longint day_number(input date_t d);
    longint      n;
    int unsigned y;
    y = d.year;
    n = 365 * longint'(y) + longint'((y + 3) / 4) - longint'((y + 99) / 100)
        + longint'((y + 399) / 400);
    for (int unsigned k = 1; k < d.month; k++) n += days_in(k, y);
    return n + longint'(d.day) - 1;
  endfunction

  function automatic overlap_t overlap_of(input logic [IN_W-1:0] item);
    date_t    dt [N_DATES];
    longint   sn [N_DATES];
    longint   len1, len2, walk_lo, walk_hi, span_lo, span_hi, lo, hi, cnt;
    overlap_t r;
    r = '0;
    for (int i = 0; i < N_DATES; i++) begin
      dt[i] = item[i*DATE_W +: DATE_W];
      if (!date_good(dt[i])) r.bad = 1'b1;
    end
    if (r.bad) return r;
    for (int i = 0; i < N_DATES; i++) sn[i] = day_number(dt[i]);
    // sn: first start, first end, second start, second end
    if (sn[3] < sn[0] || sn[2] > sn[1]) return r;
    len1 = (sn[1] > sn[0]) ? sn[1] - sn[0] : 0;
    len2 = (sn[3] > sn[2]) ? sn[3] - sn[2] : 0;
    if (len1 < len2) begin
      walk_lo = sn[0]; walk_hi = sn[1]; span_lo = sn[2]; span_hi = sn[3];
    end else begin
      walk_lo = sn[2]; walk_hi = sn[3]; span_lo = sn[0]; span_hi = sn[1];
    end
    // walked days are [walk_lo, walk_hi), the other period is closed
    lo  = (walk_lo > span_lo) ? walk_lo : span_lo;
    hi  = (walk_hi < span_hi + 1) ? walk_hi : span_hi + 1;
    cnt = (hi > lo) ? hi - lo : 0;
    if (cnt > COUNT_TOP) cnt = COUNT_TOP;
    r.days = cnt[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    overlap_t seen, want;
    if (!rst_ni) begin
      due_overlaps.delete();
      pending_o = 0;
    end else begin
      // retire first so a result never pairs with a transaction taken this edge
      if (m_tvalid_i && m_tready_i) begin
        seen.days = m_tdata_i[COUNT_W-1:0];
        seen.bad  = m_tuser_i[0];
        if (due_overlaps.size() == 0) begin
          report($sformatf("result days=%0d bad=%0b with nothing pending",
                           seen.days, seen.bad));
        end else begin
          want = due_overlaps.pop_front();
          if (seen.days !== want.days)
            report($sformatf("overlap_days %0d, predicted %0d", seen.days, want.days));
          if (seen.bad !== want.bad)
            report($sformatf("bad_date %0b, predicted %0b", seen.bad, want.bad));
        end
      end
      if (s_tvalid_i && s_tready_i) due_overlaps.push_back(overlap_of(s_tdata_i));
      pending_o = due_overlaps.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Top of the overlap-days bench. Only makes stimulus and gives the verdict:
// prediction and comparison live in overlap_days_checker, which sits beside
// the block on the same wires.
//
// Flow:
//   - directed transactions: full calendar span, disjoint and touching periods,
//     length ties, reversed periods, leap days (4/100/400 and year 0), every
//     kind of invalid date (month, day, year), all-ones fields
//   - random transactions, mostly well-formed periods packed into a few years
//     so they overlap, some wide unrelated periods, some noisy dates
//   - idling: sender light / receiver heavy, then swapped, then none; during
//     the last stretch the receiver stalls for a long run so the block fills
//     its output register, takes one more transaction and stalls its input
module tb;
  import dpod_pkg::*;

  logic             clk_i;
  logic             rst_ni;

  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // 4 dates {year, month, day} low to high, 4 zero bits
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // overlap_days, 2 zero bits
  logic [0:0]       m_axis_tuser;   // bad_date

  int               errors;
  int               pending;

  // per-cycle idle odds in percent, changed by the stimulus process per phase
  int unsigned      send_idle_pct;
  int unsigned      take_idle_pct;
  // request for one long receiver stall; the sink process clears it
  bit               hold_req;

  date_period_overlap_days dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  overlap_days_checker u_overlap_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop. It lies well past the slowest legal run, with heavy idling and
  // one long receiver stall.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Result side: random back-pressure, plus one long stall on request.
  initial begin : sink
    int unsigned held;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
    end
  end

  function automatic date_t mk(input int unsigned y, input int unsigned m,
                               input int unsigned d);
    date_t r;
    r.year  = y[YEAR_W-1:0];
    r.month = m[MON_W-1:0];
    r.day   = d[DAY_W-1:0];
    return r;
  endfunction

  // period one = a0..a1, period two = b0..b1
  function automatic logic [IN_W-1:0] periods(input date_t a0, input date_t a1,
                                              input date_t b0, input date_t b1);
    return {4'b0000, b1, b0, a1, a0};
  endfunction

  // mostly valid date within a few years of base; days 29..31 now and then,
  // which may land past the month end
  function automatic date_t near(input int unsigned base, input int unsigned spread);
    int unsigned y;
    y = base + $urandom_range(0, spread);
    if (y > 9999) y = 9999;
    return mk(y, $urandom_range(1, 12),
              ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28));
  endfunction

  function automatic date_t noise_date();
    return mk($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
  endfunction

  function automatic logic [IN_W-1:0] random_periods();
    int unsigned pick, base, mon;
    date_t       d [N_DATES];
    date_t       t;
    pick = $urandom_range(0, 99);
    // a share near either end of the calendar
    if ($urandom_range(0, 7) == 0) base = $urandom_range(0, 1) ? 0 : 9997;
    else                           base = $urandom_range(0, 9999);
    mon = $urandom_range(1, 12);
    for (int i = 0; i < N_DATES; i++) begin
      if (pick < 30)      d[i] = mk(base, mon, $urandom_range(1, 28)); // same month
      else if (pick < 70) d[i] = near(base, 2);
      else if (pick < 85) d[i] = near($urandom_range(0, 9999), 0);     // unrelated
      else                d[i] = ($urandom_range(0, 2) == 0) ? noise_date() : near(base, 1);
    end
    // well-formed share: put each period in order; the rest keeps reversed ones
    if (pick < 80) begin
      for (int i = 0; i < N_DATES; i += 2) begin
        if ({d[i].year, d[i].month, d[i].day} > {d[i+1].year, d[i+1].month, d[i+1].day}) begin
          t = d[i]; d[i] = d[i+1]; d[i+1] = t;
        end
      end
    end
    return periods(d[0], d[1], d[2], d[3]);
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic offer(input logic [IN_W-1:0] item);
    int unsigned gap;
    gap = (send_idle_pct > 50) ? $urandom_range(0, 40) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    hold_req      = 1'b0;
    send_idle_pct = 11;
    take_idle_pct = 78;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // zero-length periods, tie goes to period two: nothing walked
    offer(periods(mk(2024, 1, 1), mk(2024, 1, 1), mk(2024, 1, 1), mk(2024, 1, 1)));
    // whole calendar on both sides, the largest count
    offer(periods(mk(0, 1, 1), mk(9999, 12, 31), mk(0, 1, 1), mk(9999, 12, 31)));
    // leap February walked inside the whole calendar
    offer(periods(mk(0, 1, 1), mk(9999, 12, 31), mk(2000, 2, 1), mk(2000, 3, 1)));
    // period two ends before period one starts
    offer(periods(mk(2010, 5, 10), mk(2010, 6, 1), mk(2009, 1, 1), mk(2010, 5, 9)));
    // period two starts after period one ends
    offer(periods(mk(2010, 5, 10), mk(2010, 6, 1), mk(2010, 6, 2), mk(2011, 1, 1)));
    // touching on a single day
    offer(periods(mk(2010, 5, 10), mk(2010, 6, 1), mk(2009, 1, 1), mk(2010, 5, 10)));
    // equal lengths, partial overlap
    offer(periods(mk(2020, 1, 1), mk(2020, 1, 11), mk(2020, 1, 5), mk(2020, 1, 15)));
    // period one reversed (start after end)
    offer(periods(mk(2015, 3, 1), mk(2014, 3, 1), mk(2014, 1, 1), mk(2016, 1, 1)));
    // leap day in a 400-year
    offer(periods(mk(2000, 2, 29), mk(2000, 3, 31), mk(2000, 1, 1), mk(2000, 12, 31)));
    // century year without leap day: invalid
    offer(periods(mk(1900, 2, 29), mk(1900, 3, 31), mk(1900, 1, 1), mk(1900, 12, 31)));
    // year 0 is a leap year
    offer(periods(mk(0, 2, 29), mk(0, 3, 1), mk(0, 1, 1), mk(1, 1, 1)));
    // ordinary common year, Feb 29 invalid
    offer(periods(mk(2023, 1, 1), mk(2023, 3, 1), mk(2023, 2, 29), mk(2023, 4, 1)));
    // month zero
    offer(periods(mk(2023, 0, 5), mk(2023, 3, 1), mk(2023, 1, 1), mk(2023, 4, 1)));
    // month thirteen
    offer(periods(mk(2023, 1, 5), mk(2023, 13, 1), mk(2023, 1, 1), mk(2023, 4, 1)));
    // month all ones, day all ones
    offer(periods(mk(2023, 1, 5), mk(2023, 3, 1), mk(2023, 15, 31), mk(2023, 4, 1)));
    // day zero
    offer(periods(mk(2023, 1, 5), mk(2023, 3, 1), mk(2023, 1, 1), mk(2023, 4, 0)));
    // 31st of a 30-day month
    offer(periods(mk(2023, 4, 31), mk(2023, 5, 1), mk(2023, 1, 1), mk(2023, 6, 1)));
    // 31st of a 31-day month is fine
    offer(periods(mk(2023, 1, 31), mk(2023, 2, 1), mk(2023, 1, 1), mk(2023, 1, 31)));
    // year just past the limit
    offer(periods(mk(10000, 1, 1), mk(10000, 2, 1), mk(9999, 1, 1), mk(9999, 2, 1)));
    // every year, month and day bit set
    offer(periods(mk(9000, 1, 1), mk(9001, 1, 1), mk(9000, 6, 1), mk(16383, 15, 31)));
    // last day of the calendar
    offer(periods(mk(9998, 12, 31), mk(9999, 12, 31), mk(9999, 12, 31), mk(9999, 12, 31)));
    // across a year end
    offer(periods(mk(2023, 12, 25), mk(2024, 1, 5), mk(2023, 12, 30), mk(2024, 2, 1)));
    // period one shorter, so it is walked
    offer(periods(mk(2001, 3, 1), mk(2001, 3, 5), mk(2001, 1, 1), mk(2001, 12, 31)));

    // --- random ---
    for (int i = 0; i < 630; i++) begin
      if (i == 210) begin
        send_idle_pct = 78;
        take_idle_pct = 11;
      end
      if (i == 420) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      if (i == 470) hold_req = 1'b1;  // sender keeps offering through the stall
      offer(random_periods());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow one full transaction time for any stray result
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
